### rtl/bsfe_pkg.sv
package bsfe_pkg;

    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 32;
    localparam int REQ_W       = 2;
    localparam int MAX_BYTES   = 6;
    localparam int IDX_W       = $clog2(MAX_BYTES);
    localparam int QUEUE_DEPTH = 4;

    localparam logic [BYTE_W-1:0] FLAG_BYTE = 8'h5A;
    localparam logic [BYTE_W-1:0] ESC_BYTE  = 8'h5B;
    localparam logic [BYTE_W-1:0] CODE_ONE  = 8'h01;
    localparam logic [BYTE_W-1:0] CODE_TWO  = 8'h02;

    // Index of the closing byte for each kind of run
    localparam logic [IDX_W-1:0] LAST_START  = IDX_W'(5);
    localparam logic [IDX_W-1:0] LAST_SINGLE = IDX_W'(0);
    localparam logic [IDX_W-1:0] LAST_PAIR   = IDX_W'(1);

    typedef enum logic [REQ_W-1:0] {
        REQ_START   = 2'd0,
        REQ_NAME    = 2'd1,
        REQ_PAYLOAD = 2'd2,
        REQ_END     = 2'd3
    } req_type_t;

    // One classified item: the bytes to send, first at index 0
    typedef struct packed {
        logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes;
        logic [IDX_W-1:0]                 last_idx;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q_head_t;

endpackage

### rtl/bsfe_ifs.sv
interface bsfe_in_if;
    logic                            valid;
    logic                            ready;
    logic [bsfe_pkg::REQ_W-1:0]      req_type;
    logic [bsfe_pkg::LEN_W-1:0]      name_length;
    logic [bsfe_pkg::BYTE_W-1:0]     data_byte;

    modport source (output valid, output req_type, output name_length, output data_byte,
                    input ready);
    modport sink   (input valid, input req_type, input name_length, input data_byte,
                    output ready);
endinterface

interface bsfe_out_if;
    logic                            valid;
    logic                            ready;
    logic [bsfe_pkg::BYTE_W-1:0]     out_byte;
    logic                            last_of_run;

    modport source (output valid, output out_byte, output last_of_run, input ready);
    modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

### rtl/bsfe_front.sv
module bsfe_front (
    input  logic            clk,
    input  logic            rst_n,
    bsfe_in_if.sink         in_ch,
    output bsfe_pkg::cmd_t  push_cmd,
    output logic            push_valid,
    input  logic            push_ready
);

    logic           cmd_valid_reg;
    logic           cmd_valid_next;
    bsfe_pkg::cmd_t cmd_reg;
    bsfe_pkg::cmd_t cmd_next;
    logic           accept;

    assign in_ch.ready = !cmd_valid_reg || push_ready;
    assign accept      = in_ch.valid && in_ch.ready;
    assign push_valid  = cmd_valid_reg;
    assign push_cmd    = cmd_reg;

    // Classify the request into its byte run
    always_comb
    begin
        cmd_next.bytes    = '0;
        cmd_next.last_idx = bsfe_pkg::LAST_SINGLE;
        case (bsfe_pkg::req_type_t'(in_ch.req_type))
            bsfe_pkg::REQ_START:
            begin
                cmd_next.bytes[0] = bsfe_pkg::FLAG_BYTE;
                cmd_next.bytes[1] = bsfe_pkg::CODE_ONE;
                cmd_next.bytes[2] = in_ch.name_length[31:24];
                cmd_next.bytes[3] = in_ch.name_length[23:16];
                cmd_next.bytes[4] = in_ch.name_length[15:8];
                cmd_next.bytes[5] = in_ch.name_length[7:0];
                cmd_next.last_idx = bsfe_pkg::LAST_START;
            end
            bsfe_pkg::REQ_NAME:
            begin
                cmd_next.bytes[0] = in_ch.data_byte;
            end
            bsfe_pkg::REQ_PAYLOAD:
            begin
                if (in_ch.data_byte == bsfe_pkg::FLAG_BYTE)
                begin
                    cmd_next.bytes[0] = bsfe_pkg::ESC_BYTE;
                    cmd_next.bytes[1] = bsfe_pkg::CODE_ONE;
                    cmd_next.last_idx = bsfe_pkg::LAST_PAIR;
                end
                else if (in_ch.data_byte == bsfe_pkg::ESC_BYTE)
                begin
                    cmd_next.bytes[0] = bsfe_pkg::ESC_BYTE;
                    cmd_next.bytes[1] = bsfe_pkg::CODE_TWO;
                    cmd_next.last_idx = bsfe_pkg::LAST_PAIR;
                end
                else
                begin
                    cmd_next.bytes[0] = in_ch.data_byte;
                end
            end
            bsfe_pkg::REQ_END:
            begin
                cmd_next.bytes[0] = bsfe_pkg::FLAG_BYTE;
                cmd_next.bytes[1] = bsfe_pkg::CODE_TWO;
                cmd_next.last_idx = bsfe_pkg::LAST_PAIR;
            end
            default:
            begin
                cmd_next.bytes[0] = in_ch.data_byte;
            end
        endcase
    end

    always_comb
    begin
        cmd_valid_next = cmd_valid_reg;
        if (accept)
            cmd_valid_next = 1'b1;
        else if (push_ready)
            cmd_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cmd_valid_reg <= 1'b0;
        else
            cmd_valid_reg <= cmd_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            cmd_reg <= cmd_next;
    end

endmodule

### rtl/bsfe_queue.sv
module bsfe_queue #(
    parameter int DEPTH = bsfe_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  bsfe_pkg::cmd_t    push_cmd,
    input  logic              push_valid,
    output logic              push_ready,
    output bsfe_pkg::q_head_t head,
    input  logic              pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    bsfe_pkg::cmd_t   mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.cmd   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && head.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

### rtl/bsfe_back.sv
module bsfe_back (
    input  logic              clk,
    input  logic              rst_n,
    input  bsfe_pkg::q_head_t head,
    output logic              pop,
    bsfe_out_if.source        out_ch
);

    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [bsfe_pkg::BYTE_W-1:0]   out_byte_reg;
    logic [bsfe_pkg::BYTE_W-1:0]   out_byte_next;
    logic                          out_last_reg;
    logic                          out_last_next;
    logic [bsfe_pkg::IDX_W-1:0]    idx_reg;
    logic [bsfe_pkg::IDX_W-1:0]    idx_next;
    logic                          advance;
    logic                          at_last;

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.out_byte    = out_byte_reg;
    assign out_ch.last_of_run = out_last_reg;

    assign advance = !out_valid_reg || out_ch.ready;
    assign at_last = (idx_reg == head.cmd.last_idx);

    // Walk the head run one byte per cycle while the output is not stalled; drop it once its last byte is loaded
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        idx_next       = idx_reg;
        pop            = 1'b0;
        if (advance)
        begin
            out_valid_next = head.valid;
            if (head.valid)
            begin
                out_byte_next = head.cmd.bytes[idx_reg];
                out_last_next = at_last;
                if (at_last)
                begin
                    pop      = 1'b1;
                    idx_next = '0;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

endmodule

### rtl/byte_stuffing_frame_encoder.sv
// Path: an input transfer goes through the front register, the command queue and the output
// register. Throughput: one output byte per cycle while the sink is ready, set by the
// single-byte output port; an item is 1 byte (name or plain payload), 2 (escaped byte or end)
// or 6 (start header). Input is taken every cycle while the command queue has room.
// Reset (rst_n, asynchronous, active low) empties the front register, the queue and the
// output register; no output is valid until an item has been taken.
module byte_stuffing_frame_encoder #(
    parameter int QUEUE_DEPTH = bsfe_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    bsfe_in_if.sink     in_ch,
    bsfe_out_if.source  out_ch
);

    // Front: take each request transfer and turn it into a run of up to six bytes,
    // held in one register until the queue has room.
    bsfe_pkg::cmd_t    push_cmd;
    logic              push_valid;
    logic              push_ready;

    // Queue to back: the oldest run waiting to be sent, and the pop that retires it.
    bsfe_pkg::q_head_t head;
    logic              pop;

    bsfe_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .push_cmd   (push_cmd),
        .push_valid (push_valid),
        .push_ready (push_ready)
    );

    // Short queue decouples the two sides: the front keeps taking requests while
    // the back is still serialising a long header or is stalled by the sink.
    bsfe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_cmd   (push_cmd),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .head       (head),
        .pop        (pop)
    );

    // Back: send the head run byte by byte through the output register, marking the
    // closing byte of each run, and release the run as that byte is loaded.
    bsfe_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .pop    (pop),
        .out_ch (out_ch)
    );

endmodule

### rtl/bsfe_checker.sv
module bsfe_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [bsfe_pkg::BYTE_W-1:0]   out_byte,
    input logic                          out_last
);

    logic [7:0] pending_reg;
    logic [7:0] pending_next;
    logic       in_xfer;
    logic       out_done;

    assign in_xfer  = in_valid && in_ready;
    assign out_done = out_valid && out_ready && out_last;

    // Count items taken whose runs are not yet fully transferred
    always_comb
    begin
        pending_next = pending_reg;
        if (in_xfer && !out_done)
            pending_next = pending_reg + 1'b1;
        else if (out_done && !in_xfer)
            pending_next = pending_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else
            pending_reg <= pending_next;
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
        else $error("output changed while stalled");

    a_no_invented_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_done |-> pending_reg != 8'd0)
        else $error("run closed with no item outstanding");

    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg == 8'd0 |-> in_ready)
        else $error("input not ready while empty");

    a_run_gapless: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_last |=> out_valid)
        else $error("gap inside a byte run");

endmodule

bind byte_stuffing_frame_encoder bsfe_checker u_bsfe_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_byte  (out_ch.out_byte),
    .out_last  (out_ch.last_of_run)
);
